FILE: src/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// types and codes shared by the sorted set table modules
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMKEY = 3'd1;
    localparam logic [2:0] MODE_REMIDX = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [2:0] ST_EXISTING  = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX = 3'd5;
    localparam logic [2:0] ST_READ_OK   = 3'd6;
    localparam logic [2:0] ST_CLEARED   = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_READ,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic search;    // one binary search step
        logic shift;     // one move of an entry
        logic rd_issue;  // issue read at index
        logic finish;    // compute result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic search_done;
        logic need_shift;
        logic shift_done;
        logic is_search;
        logic is_read;
    } stat_t;

endpackage

FILE: src/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl
// request sequencer: search, shift, read and result hand-off
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_fire,
    input  logic           m_fire,
    input  sst_pkg::stat_t stat,
    output sst_pkg::cmd_t  cmd,
    output logic           s_ready,
    output logic           m_valid
);

    sst_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sst_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sst_pkg::S_IDLE: begin
                if (s_fire) begin
                    state_next = sst_pkg::S_SEARCH;
                end
            end
            sst_pkg::S_SEARCH: begin
                if (stat.is_read) begin
                    state_next = sst_pkg::S_READ;
                end else if (!stat.is_search || stat.search_done) begin
                    state_next = stat.need_shift ? sst_pkg::S_SHIFT : sst_pkg::S_DONE;
                end
            end
            sst_pkg::S_SHIFT: begin
                if (stat.shift_done) begin
                    state_next = sst_pkg::S_DONE;
                end
            end
            sst_pkg::S_READ: begin
                state_next = sst_pkg::S_DONE;
            end
            sst_pkg::S_DONE: begin
                if (m_fire) begin
                    state_next = sst_pkg::S_IDLE;
                end
            end
            default: state_next = sst_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        unique case (state_reg)
            sst_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_fire;
            end
            sst_pkg::S_SEARCH: begin
                cmd.search   = stat.is_search && !stat.search_done;
                cmd.rd_issue = stat.is_read;
                cmd.finish   = !stat.is_read && (!stat.is_search || stat.search_done);
            end
            sst_pkg::S_SHIFT: begin
                cmd.shift = 1'b1;
            end
            sst_pkg::S_READ: begin
                cmd.finish = 1'b1;
            end
            sst_pkg::S_DONE: begin
                m_valid = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: src/sst_dp.sv
// ----------------------------------------------------------------------------
// sst_dp
// key store, binary search and entry shifting datapath
// ----------------------------------------------------------------------------
module sst_dp #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  sst_pkg::cmd_t  cmd,
    output sst_pkg::stat_t stat,
    input  logic [2:0]     in_mode,
    input  logic [31:0]    in_key,
    input  logic [7:0]     in_index,
    output logic [2:0]     out_status,
    output logic [7:0]     out_position,
    output logic [31:0]    out_value,
    output logic [8:0]     out_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [2:0]           mode_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [7:0]           index_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        lo_reg, hi_reg;
    logic [CW-1:0]        sidx_reg;       // shift cursor
    logic                 sphase_reg;     // 0 read issue, 1 write
    logic                 rpend_reg;      // search read outstanding
    logic [CW-1:0]        pos_reg;
    logic                 found_reg;
    logic                 ins_reg;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [KEY_WIDTH-1:0] wdata, rdata;
    logic [CW-1:0]        mid;
    logic                 is_search;
    logic                 need_shift;
    logic                 idx_ok;

    sst_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign is_search = (mode_reg == sst_pkg::MODE_ADD) || (mode_reg == sst_pkg::MODE_REMKEY);
    assign idx_ok    = 32'(index_reg) < 32'(count_reg);

    // search is done when range empty and no read outstanding; the lower bound pos
    // needs no extra read to compare against its key, as found_reg marks any probed match
    assign stat.is_search   = is_search;
    assign stat.search_done = (lo_reg == hi_reg) && !rpend_reg;
    assign stat.is_read     = (mode_reg == sst_pkg::MODE_READ) && idx_ok && !rpend_reg;
    assign stat.shift_done  = sphase_reg && (ins_reg ? (sidx_reg == pos_reg)
                                                      : (sidx_reg + 1'b1 >= count_reg));
    assign stat.need_shift  = need_shift;

    // lower bound result is lo; exact match if some probed entry equal key
    always_comb begin
        need_shift = 1'b0;
        unique case (mode_reg)
            sst_pkg::MODE_ADD:    need_shift = !found_reg && (count_reg != CW'(CAPACITY));
            sst_pkg::MODE_REMKEY: need_shift = found_reg;
            sst_pkg::MODE_REMIDX: need_shift = idx_ok;
            default:              need_shift = 1'b0;
        endcase
    end

    always_comb begin
        raddr = AW'(mid);
        we    = 1'b0;
        waddr = AW'(sidx_reg);
        wdata = rdata;
        if (cmd.rd_issue) begin
            raddr = AW'(index_reg);
        end else if (cmd.shift) begin
            if (ins_reg) begin
                raddr = AW'(sidx_reg - 1'b1);
                if (sphase_reg) begin
                    we = 1'b1;
                    if (sidx_reg == pos_reg) begin
                        wdata = key_reg;
                    end
                end
            end else begin
                raddr = AW'(sidx_reg + 1'b1);
                we    = sphase_reg && (sidx_reg + 1'b1 < count_reg);
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.shift && stat.shift_done) begin
            count_next = ins_reg ? count_reg + 1'b1 : count_reg - 1'b1;
        end else if (cmd.finish && mode_reg == sst_pkg::MODE_CLEAR) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rpend_reg  <= 1'b0;
            sphase_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load) begin
                rpend_reg  <= 1'b0;
                sphase_reg <= 1'b0;
            end else if (cmd.search) begin
                rpend_reg <= !rpend_reg;
            end else if (cmd.rd_issue) begin
                rpend_reg <= 1'b1;
            end else if (cmd.shift) begin
                sphase_reg <= !sphase_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= in_mode;
            key_reg   <= KEY_WIDTH'(in_key);
            index_reg <= in_index;
            lo_reg    <= '0;
            hi_reg    <= count_reg;
            found_reg <= 1'b0;
        end else if (cmd.search && rpend_reg) begin
            if (rdata < key_reg) begin
                lo_reg <= mid + 1'b1;
            end else begin
                hi_reg <= mid;
                if (rdata == key_reg) begin
                    found_reg <= 1'b1;
                end
            end
        end
        if (cmd.finish && !cmd.rd_issue && is_search) begin
            pos_reg  <= lo_reg;
            ins_reg  <= (mode_reg == sst_pkg::MODE_ADD);
            sidx_reg <= (mode_reg == sst_pkg::MODE_ADD) ? count_reg : lo_reg;
        end else if (cmd.finish && mode_reg == sst_pkg::MODE_REMIDX) begin
            pos_reg  <= CW'(index_reg);
            ins_reg  <= 1'b0;
            sidx_reg <= CW'(index_reg);
        end else if (cmd.shift && sphase_reg && !stat.shift_done) begin
            sidx_reg <= ins_reg ? sidx_reg - 1'b1 : sidx_reg + 1'b1;
        end
        if (cmd.finish) begin
            out_value    <= '0;
            out_position <= '0;
            unique case (mode_reg)
                sst_pkg::MODE_ADD: begin
                    if (found_reg) begin
                        out_status   <= sst_pkg::ST_EXISTING;
                        out_position <= 8'(lo_reg);
                    end else if (count_reg == CW'(CAPACITY)) begin
                        out_status <= sst_pkg::ST_FULL;
                    end else begin
                        out_status   <= sst_pkg::ST_INSERTED;
                        out_position <= 8'(lo_reg);
                    end
                end
                sst_pkg::MODE_REMKEY: begin
                    out_status   <= found_reg ? sst_pkg::ST_REMOVED : sst_pkg::ST_NOT_FOUND;
                    out_position <= found_reg ? 8'(lo_reg) : 8'd0;
                end
                sst_pkg::MODE_REMIDX: begin
                    out_status   <= idx_ok ? sst_pkg::ST_REMOVED : sst_pkg::ST_BAD_INDEX;
                    out_position <= idx_ok ? index_reg : 8'd0;
                end
                sst_pkg::MODE_READ: begin
                    out_status   <= rpend_reg ? sst_pkg::ST_READ_OK : sst_pkg::ST_BAD_INDEX;
                    out_position <= rpend_reg ? index_reg : 8'd0;
                    out_value    <= rpend_reg ? 32'(rdata) : 32'd0;
                end
                sst_pkg::MODE_CLEAR: out_status <= sst_pkg::ST_CLEARED;
                default:             out_status <= sst_pkg::ST_BAD_INDEX;
            endcase
        end
    end

    assign out_count = 9'(count_reg);

endmodule

FILE: src/sorted_set_table_core.sv
// ----------------------------------------------------------------------------
// sorted_set_table_core
// ordered set of unique keys with add, remove, read and clear requests
// ----------------------------------------------------------------------------
// One request at a time. The keys sit ascending in a single ram with a
// registered read port. Key lookups run a binary search, with a read issue
// and then a compare for each probe; an insert or remove then moves the
// entries from the position upward through the single ram, reading each
// entry and then writing it one slot over. Read at index issues one read and
// registers its data. The result beat holds until
// taken; count reflects the set after the request.
module sorted_set_table_core #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[2:0], key[34:3], index[42:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[2:0], position[10:3], value[42:11], count[51:43]
);

    sst_pkg::cmd_t  cmd;
    sst_pkg::stat_t stat;
    logic [2:0]     status;
    logic [7:0]     position;
    logic [31:0]    value;
    logic [8:0]     count;

    sst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_fire  (s_tvalid && s_tready),
        .m_fire  (m_tvalid && m_tready),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_tready),
        .m_valid (m_tvalid)
    );

    sst_dp #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_mode      (s_tdata[2:0]),
        .in_key       (s_tdata[34:3]),
        .in_index     (s_tdata[42:35]),
        .out_status   (status),
        .out_position (position),
        .out_value    (value),
        .out_count    (count)
    );

    assign m_tdata = {4'd0, count, value, position, status};

endmodule

FILE: tb/tb_sorted_set_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_set_table_core
// self-checking test of the sorted set table core
// ----------------------------------------------------------------------------
// Requests go in on the slave stream. A behavioral copy of the ordered key
// set predicts the status, position, value and count of every request, and
// each result beat is compared with the oldest pending prediction. Directed
// cases cover the corner cases first, then random traffic with varying
// backpressure and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_set_table_core;

    localparam int DEPTH = 256;

    // status in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [8:0]  count;
        logic [31:0] value;
        logic [7:0]  position;
        logic [2:0]  status;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    logic [31:0] set_keys [DEPTH];
    int          set_size;
    answer_t     answers_due[$];
    int          errors;
    int          beats_sent;
    int          beats_checked;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_req  = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    sorted_set_table_core #(.CAPACITY(DEPTH), .KEY_WIDTH(32)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic answer_t apply_request(logic [2:0] mode, logic [31:0] key,
                                              logic [7:0] index);
        answer_t a;
        int pos;
        a = '0;
        a.status = sst_pkg::ST_BAD_INDEX;
        pos = 0;
        if (mode == sst_pkg::MODE_ADD || mode == sst_pkg::MODE_REMKEY) begin
            while (pos < set_size && set_keys[pos] < key)
                pos++;
        end
        case (mode)
            sst_pkg::MODE_ADD: begin
                if (pos < set_size && set_keys[pos] == key) begin
                    a.status = sst_pkg::ST_EXISTING;
                    a.position = pos[7:0];
                end else if (set_size >= DEPTH) begin
                    a.status = sst_pkg::ST_FULL;
                end else begin
                    for (int i = set_size; i > pos; i--)
                        set_keys[i] = set_keys[i-1];
                    set_keys[pos] = key;
                    set_size++;
                    a.status = sst_pkg::ST_INSERTED;
                    a.position = pos[7:0];
                end
            end
            sst_pkg::MODE_REMKEY: begin
                if (pos < set_size && set_keys[pos] == key) begin
                    for (int i = pos; i + 1 < set_size; i++)
                        set_keys[i] = set_keys[i+1];
                    set_size--;
                    a.status = sst_pkg::ST_REMOVED;
                    a.position = pos[7:0];
                end else begin
                    a.status = sst_pkg::ST_NOT_FOUND;
                end
            end
            sst_pkg::MODE_REMIDX: begin
                if (index < set_size) begin
                    for (int i = index; i + 1 < set_size; i++)
                        set_keys[i] = set_keys[i+1];
                    set_size--;
                    a.status = sst_pkg::ST_REMOVED;
                    a.position = index;
                end
            end
            sst_pkg::MODE_READ: begin
                if (index < set_size) begin
                    a.status = sst_pkg::ST_READ_OK;
                    a.position = index;
                    a.value = set_keys[index];
                end
            end
            sst_pkg::MODE_CLEAR: begin
                set_size = 0;
                a.status = sst_pkg::ST_CLEARED;
            end
            default: ;
        endcase
        a.count = set_size[8:0];
        return a;
    endfunction

    // tvalid stays high after the accept until the next request or an idle cycle
    task automatic send_request(logic [2:0] mode, logic [31:0] key, logic [7:0] index);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, index, key, mode};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        answers_due.push_back(apply_request(mode, key, index));
        beats_sent++;
    endtask

    // receiver ready, with random idling or a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 3000;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        answer_t got;
        answer_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[51:0];
            beats_checked++;
            if (answers_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
            end else begin
                exp = answers_due.pop_front();
                if (got.status !== exp.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp.status, got.status);
                end
                if (got.position !== exp.position) begin
                    errors++;
                    $display("%0t: position expected %0d actual %0d", $time,
                             exp.position, got.position);
                end
                if (got.value !== exp.value) begin
                    errors++;
                    $display("%0t: value expected %h actual %h", $time,
                             exp.value, got.value);
                end
                if (got.count !== exp.count) begin
                    errors++;
                    $display("%0t: count expected %0d actual %0d", $time,
                             exp.count, got.count);
                end
            end
        end
    end

    function automatic logic [31:0] pick_key(int span);
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(3, 0);
            2: return $urandom_range(3, 0);
            default: return $urandom_range(span, 0);
        endcase
    endfunction

    task automatic test_directed();
        send_request(sst_pkg::MODE_REMKEY, 32'd5, 8'd0);
        send_request(sst_pkg::MODE_REMIDX, 32'd0, 8'd0);
        send_request(sst_pkg::MODE_READ, 32'd0, 8'd0);
        send_request(sst_pkg::MODE_ADD, 32'd0, 8'd0);
        send_request(sst_pkg::MODE_REMKEY, 32'd0, 8'd0);
        send_request(sst_pkg::MODE_ADD, 32'hFFFF_FFFF, 8'd0);
        send_request(sst_pkg::MODE_ADD, 32'd0, 8'd0);
        send_request(sst_pkg::MODE_ADD, 32'h8000_0000, 8'd0);
        send_request(sst_pkg::MODE_ADD, 32'h8000_0000, 8'd0);
        send_request(sst_pkg::MODE_READ, 32'd0, 8'd2);
        send_request(sst_pkg::MODE_READ, 32'd0, 8'd3);
        send_request(sst_pkg::MODE_READ, 32'd0, 8'd255);
        send_request(sst_pkg::MODE_REMIDX, 32'd0, 8'd1);
        send_request(sst_pkg::MODE_REMIDX, 32'd0, 8'd200);
        send_request(3'd5, 32'hFFFF_FFFF, 8'hFF);
        send_request(3'd6, 32'd1, 8'd0);
        send_request(3'd7, 32'd2, 8'd1);
        send_request(sst_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 8'hFF);
        send_request(sst_pkg::MODE_READ, 32'd0, 8'd0);
    endtask

    // fill to capacity, add a new and an existing key to the full store, read and remove by index, remove by key, clear
    task automatic test_full_store();
        while (set_size < DEPTH)
            send_request(sst_pkg::MODE_ADD, $urandom(), 8'd0);
        send_request(sst_pkg::MODE_ADD, 32'h1234_5678, 8'd0);
        send_request(sst_pkg::MODE_ADD, set_keys[100], 8'd0);
        send_request(sst_pkg::MODE_READ, 32'd0, 8'd255);
        send_request(sst_pkg::MODE_REMIDX, 32'd0, 8'd255);
        send_request(sst_pkg::MODE_REMIDX, 32'd0, 8'd0);
        for (int i = 0; i < 40; i++)
            send_request(sst_pkg::MODE_REMKEY, set_keys[$urandom_range(set_size - 1, 0)],
                         8'($urandom()));
        send_request(sst_pkg::MODE_CLEAR, 32'd0, 8'd0);
    endtask

    task automatic test_random(int n, int span);
        logic [2:0] mode;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19, 0))
                0, 1, 2, 3, 4, 5, 6: mode = sst_pkg::MODE_ADD;
                7, 8, 9:             mode = sst_pkg::MODE_REMKEY;
                10, 11:              mode = sst_pkg::MODE_REMIDX;
                12, 13, 14, 15:      mode = sst_pkg::MODE_READ;
                16:                  mode = (i % 4 == 0) ? sst_pkg::MODE_CLEAR
                                                         : sst_pkg::MODE_READ;
                17:                  mode = 3'($urandom_range(7, 5));
                default:             mode = sst_pkg::MODE_REMKEY;
            endcase
            if (mode == sst_pkg::MODE_REMKEY && set_size > 0 && $urandom_range(1, 0))
                send_request(mode, set_keys[$urandom_range(set_size - 1, 0)],
                             8'($urandom()));
            else
                send_request(mode, pick_key(span),
                             ($urandom_range(3, 0) == 0) ? 8'($urandom())
                                 : 8'($urandom_range(set_size + 1, 0)));
        end
    endtask

    task automatic test_long_hold();
        hold_req++;
        test_random(30, 1000);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (answers_due.size() > 0)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        set_size = 0;
        send_idle_pct = 32;
        recv_idle_pct = 58;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(500, 300);
        send_idle_pct = 58;
        recv_idle_pct = 32;
        test_full_store();
        test_random(500, 100000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_long_hold();
        test_random(500, 60);
        wait_idle();
        $display("sent %0d requests, checked %0d results over add, remove, read,",
                 beats_sent, beats_checked);
        $display("clear, full store, bad index and unused modes under backpressure");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout with %0d results pending", answers_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
